/* rtl/olt_pkg.sv */
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VAL_W       = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // per-request cell controls, broadcast to every cell
    typedef struct packed {
        logic ins;   // shift toward tail, head takes key
        logic del;   // cells at or past the first match pull from the tail side
        logic upd;   // first matching cell takes new value
    } t_cell_ctl;

endpackage

/* rtl/ordered_list_table_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_table_core
// Ordered list of signed 32-bit values held in a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Result strobe o_done is registered: it rises in the cycle after the request transfer.
// Throughput: one request per cycle; every cell compares and shifts in the
//   same cycle, the first-match chain across the cells sets the cycle time.
// busy stays low: the receiver cannot stall and no request is held off.
// Reset (synchronous, active low) empties the list; cell contents are kept.
module ordered_list_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_new_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_match_position,
    output logic [4:0]  o_entry_count
);

    localparam int N = olt_pkg::MAX_ENTRIES;

    logic [olt_pkg::CNT_W-1:0] r_count, n_count;
    logic [olt_pkg::POS_W-1:0] r_pos, n_pos;
    olt_pkg::t_status          r_status, n_status;
    logic                      r_done;

    logic                      w_accept;
    logic                      w_full;
    olt_pkg::t_op              w_op;
    olt_pkg::t_cell_ctl        w_ctl;
    logic [olt_pkg::VAL_W-1:0] w_val [N];
    logic [N:0]                w_hit;
    logic [N-1:0]              w_first;
    logic [N-1:0]              w_live;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_op     = olt_pkg::t_op'(i_req_type);
    assign w_full   = (r_count == olt_pkg::CNT_W'(N));
    assign w_hit[0] = 1'b0;

    always_comb begin
        w_ctl.ins = w_accept && (w_op == olt_pkg::OP_INSERT) && !w_full;
        w_ctl.del = w_accept && (w_op == olt_pkg::OP_DELETE);
        w_ctl.upd = w_accept && (w_op == olt_pkg::OP_UPDATE);
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [olt_pkg::VAL_W-1:0] w_head_side;
            logic [olt_pkg::VAL_W-1:0] w_tail_side;

            assign w_live[g] = (olt_pkg::CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_head_side = i_key;
            end else begin : g_mid
                assign w_head_side = w_val[g-1];
            end
            // last cell past a delete is outside the list; any value serves
            if (g == N - 1) begin : g_tail
                assign w_tail_side = w_val[g];
            end else begin : g_body
                assign w_tail_side = w_val[g+1];
            end

            olt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_live      (w_live[g]),
                .i_key       (i_key),
                .i_new_value (i_new_value),
                .i_head_side (w_head_side),
                .i_tail_side (w_tail_side),
                .i_hit       (w_hit[g]),
                .o_hit       (w_hit[g+1]),
                .o_first     (w_first[g]),
                .o_value     (w_val[g])
            );
        end
    endgenerate

    // one-hot first-match flags to position
    always_comb begin
        n_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (w_first[i]) begin
                n_pos = n_pos | olt_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = olt_pkg::ST_OK;
        unique case (w_op)
            olt_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = olt_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            olt_pkg::OP_DELETE: begin
                if (w_hit[N]) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = olt_pkg::ST_NOMATCH;
                end
            end
            olt_pkg::OP_UPDATE,
            olt_pkg::OP_SEARCH: begin
                if (!w_hit[N]) begin
                    n_status = olt_pkg::ST_NOMATCH;
                end
            end
            default: n_status = olt_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pos    <= (w_op == olt_pkg::OP_INSERT) ? '0 : n_pos;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_match_position = 4'(r_pos);
    assign o_entry_count    = 5'(r_count);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olt_pkg::CNT_W'(N))
        else $error("entry count above capacity");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("transfer without result strobe");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == olt_pkg::ST_FULL) |-> r_count == olt_pkg::CNT_W'(N))
        else $error("full status with room left");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the list");

endmodule

/* rtl/olt_cell.sv */
// ----------------------------------------------------------------------------
// olt_cell
// One list position: holds a value, compares it with the key and passes the
// first-match chain and its value on to its neighbors.
// ----------------------------------------------------------------------------
module olt_cell (
    input  logic                            i_clk,
    input  olt_pkg::t_cell_ctl              i_ctl,
    input  logic                            i_live,
    input  logic [olt_pkg::VAL_W-1:0]       i_key,
    input  logic [olt_pkg::VAL_W-1:0]       i_new_value,
    input  logic [olt_pkg::VAL_W-1:0]       i_head_side,
    input  logic [olt_pkg::VAL_W-1:0]       i_tail_side,
    input  logic                            i_hit,
    output logic                            o_hit,
    output logic                            o_first,
    output logic [olt_pkg::VAL_W-1:0]       o_value
);

    logic [olt_pkg::VAL_W-1:0] r_value;
    logic [olt_pkg::VAL_W-1:0] n_value;
    logic                      w_eq;

    assign w_eq    = i_live && (r_value == i_key);
    assign o_first = w_eq && !i_hit;
    assign o_hit   = i_hit || w_eq;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ins) begin
            n_value = i_head_side;
        end else if (i_ctl.del && o_hit) begin
            n_value = i_tail_side;
        end else if (i_ctl.upd && o_first) begin
            n_value = i_new_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* verif/ordered_list_table_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_table_core_tb
// Self-checking bench for the ordered list table. Requests are queued up
// front and fed by a clocked driver with random idle bursts. A shadow copy
// of the list predicts each status / position / count. A monitor compares
// every o_done transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_list_table_core_tb;

    localparam int CYCLE_LIMIT = 60000;

    typedef struct {
        olt_pkg::t_op op;
        logic [31:0]  key;
        logic [31:0]  new_value;
        int           idle;     // idle cycles before presenting
        bit           drain;    // hold until all results are back
    } t_list_req;

    typedef struct {
        olt_pkg::t_status status;
        logic [3:0]       position;
        logic [4:0]       count;
    } t_list_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_new_value = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [3:0]  o_match_position;
    logic [4:0]  o_entry_count;

    ordered_list_table_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_key            (i_key),
        .i_new_value      (i_new_value),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_match_position (o_match_position),
        .o_entry_count    (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    // shadow list
    logic [31:0] shadow_vals [olt_pkg::MAX_ENTRIES];
    int          shadow_len = 0;

    t_list_req   pending_reqs [$];
    t_list_rsp   expected_rsps [$];
    logic [31:0] key_pool [6];

    t_list_req   cur_req;
    bit          cur_loaded = 1'b0;
    int          idle_left = 0;
    logic        drv_go;
    int          accepted_cnt = 0;
    int          total_items = 0;
    int          err_count = 0;
    int          cycle_count = 0;

    task automatic apply_request(input t_list_req rq, output t_list_rsp rsp);
        int hit;
        hit = shadow_len;
        rsp.status   = olt_pkg::ST_OK;
        rsp.position = '0;
        if (rq.op == olt_pkg::OP_INSERT) begin
            if (shadow_len >= olt_pkg::MAX_ENTRIES) begin
                rsp.status = olt_pkg::ST_FULL;
            end else begin
                for (int i = olt_pkg::MAX_ENTRIES - 1; i > 0; i--)
                    shadow_vals[i] = shadow_vals[i - 1];
                shadow_vals[0] = rq.key;
                shadow_len++;
            end
        end else begin
            for (int i = 0; i < olt_pkg::MAX_ENTRIES; i++) begin
                if (i < shadow_len && hit == shadow_len && shadow_vals[i] == rq.key)
                    hit = i;
            end
            if (hit >= shadow_len) begin
                rsp.status = olt_pkg::ST_NOMATCH;
            end else begin
                rsp.position = hit[3:0];
                if (rq.op == olt_pkg::OP_DELETE) begin
                    for (int i = hit; i < olt_pkg::MAX_ENTRIES - 1; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_len--;
                end else if (rq.op == olt_pkg::OP_UPDATE) begin
                    shadow_vals[hit] = rq.new_value;
                end
            end
        end
        rsp.count = shadow_len[4:0];
    endtask

    function automatic void add_request(olt_pkg::t_op op, logic [31:0] key,
                                        logic [31:0] nv, int idle, bit drain);
        t_list_req rq;
        rq.op        = op;
        rq.key       = key;
        rq.new_value = nv;
        rq.idle      = idle;
        rq.drain     = drain;
        pending_reqs.push_back(rq);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_list_rsp rsp;
        drv_go = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                apply_request(cur_req, rsp);
                expected_rsps.push_back(rsp);
                accepted_cnt++;
                cur_loaded = 1'b0;
            end
            if (start && busy) begin
                drv_go = 1'b1;
            end else begin
                if (!cur_loaded && pending_reqs.size() > 0) begin
                    cur_req    = pending_reqs.pop_front();
                    idle_left  = cur_req.idle;
                    cur_loaded = 1'b1;
                end
                if (cur_loaded) begin
                    if (idle_left > 0)
                        idle_left--;
                    else if (!(cur_req.drain && expected_rsps.size() > 0))
                        drv_go = 1'b1;
                end
            end
        end
        start       <= drv_go;
        i_req_type  <= cur_req.op;
        i_key       <= cur_req.key;
        i_new_value <= cur_req.new_value;
    end

    // monitor
    always @(posedge i_clk) begin
        t_list_rsp exp_rsp;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (o_status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, o_status);
                    err_count++;
                end
                if (o_match_position !== exp_rsp.position) begin
                    $error("match_position: expected %0d, got %0d",
                           exp_rsp.position, o_match_position);
                    err_count++;
                end
                if (o_entry_count !== exp_rsp.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_rsp.count, o_entry_count);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ordered_list_table_core test failed");
            $finish;
        end
    end

    initial begin
        olt_pkg::t_op op;
        logic [31:0]  key;
        logic [31:0]  nv;
        int           idle;
        int           pick;
        int           ins_pct;
        bit           idle_on;
        bit           drain;

        // empty list: nothing to match
        add_request(olt_pkg::OP_SEARCH, 32'h0000_0000, $urandom, 0, 1'b0);
        add_request(olt_pkg::OP_DELETE, 32'hFFFF_FFFF, $urandom, 1, 1'b0);
        add_request(olt_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        // fill to the top; oldest entry ends at the tail
        add_request(olt_pkg::OP_INSERT, 32'h8000_0000, $urandom, 0, 1'b0);
        add_request(olt_pkg::OP_INSERT, 32'h7FFF_FFFF, $urandom, 0, 1'b0);
        add_request(olt_pkg::OP_INSERT, 32'h0000_0000, $urandom, 2, 1'b0);
        add_request(olt_pkg::OP_INSERT, 32'hFFFF_FFFF, $urandom, 0, 1'b0);
        for (int i = 0; i < 12; i++)
            add_request(olt_pkg::OP_INSERT, (i % 3 == 0) ? 32'h0000_0005 : $urandom,
                        $urandom, 0, 1'b0);
        // full, rejected
        add_request(olt_pkg::OP_INSERT, 32'h1234_5678, $urandom, 0, 1'b1);
        // hit at tail
        add_request(olt_pkg::OP_SEARCH, 32'h8000_0000, $urandom, 0, 1'b0);
        add_request(olt_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        // first of duplicates
        add_request(olt_pkg::OP_SEARCH, 32'h7FFF_FFFF, $urandom, 0, 1'b0);
        // first dup near head
        add_request(olt_pkg::OP_DELETE, 32'h0000_0005, $urandom, 1, 1'b0);
        add_request(olt_pkg::OP_INSERT, 32'h0000_0005, 32'h0000_0000, 0, 1'b0);

        // random part: alternating fill- and drain-biased phases
        for (int ph = 0; ph < 10; ph++) begin
            for (int j = 0; j < 6; j++)
                key_pool[j] = $urandom;
            ins_pct = (ph % 2 == 0) ? 70 : 15;
            idle_on = (ph % 3 != 2);
            for (int k = 0; k < 80; k++) begin
                idle = (ph < 8 && idle_on && $urandom_range(0, 3) == 0)
                       ? $urandom_range(1, 4) : 0;
                drain = (k == 0) || ($urandom_range(0, 99) == 0);
                pick = $urandom_range(0, 99);
                if (pick < ins_pct) begin
                    op = olt_pkg::OP_INSERT;
                end else begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2)
                        op = olt_pkg::OP_DELETE;
                    else if (pick == 2)
                        op = olt_pkg::OP_UPDATE;
                    else
                        op = olt_pkg::OP_SEARCH;
                end
                key = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
                nv  = ($urandom_range(0, 1) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
                add_request(op, key, nv, idle, drain);
            end
        end
        total_items = pending_reqs.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_items)
            @(posedge i_clk);
        while (expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (err_count == 0)
            $display("ordered_list_table_core test passed");
        else
            $display("ordered_list_table_core test failed");
        $finish;
    end

endmodule
